>>> hw/rtl/sem_pkg.sv
// Shared types and constants for the Sobel edge magnitude block.
`timescale 1ns / 1ps
`default_nettype none

package sem_pkg;

    // Fixed widths of the request and result fields
    localparam int PIX_IN_W = 8;
    localparam int COORD_W  = 6;
    localparam int MAG_W    = 11;

    // Largest magnitude the result field can carry
    localparam logic [MAG_W-1:0] MAG_MAX = 11'h7ff;

    // Control part of one job handed from front to back
    typedef struct packed {
        logic               has_a;       // left border or interior result
        logic               a_interior;  // first result needs the square root
        logic               has_b;       // right border of the row above
        logic               has_c;       // pixel itself, first or last row
        logic               frame_last;  // job holds the last result of the frame
        logic [COORD_W-1:0] a_row;
        logic [COORD_W-1:0] a_col;
        logic [COORD_W-1:0] cur_row;
        logic [COORD_W-1:0] cur_col;
    } sem_job_t;

endpackage

`default_nettype wire

>>> hw/rtl/sem_front.sv
// Front end: accepts pixels, keeps line stores and window, classifies each pixel into a job.
`timescale 1ns / 1ps
`default_nettype none

module sem_front #(
    parameter int IMG_WIDTH  = 64,
    parameter int IMG_HEIGHT = 64,
    parameter int PIXEL_BITS = 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [sem_pkg::PIX_IN_W-1:0]  s_pixel,
    output logic                               push_valid,
    input  wire logic                          push_ready,
    output sem_pkg::sem_job_t                  push_job,
    output logic signed [PIXEL_BITS+2:0]       push_gx,
    output logic signed [PIXEL_BITS+2:0]       push_gy,
    output logic [PIXEL_BITS-1:0]              push_pa,
    output logic [PIXEL_BITS-1:0]              push_pb,
    output logic [PIXEL_BITS-1:0]              push_pc
);

    localparam int P    = PIXEL_BITS;
    localparam int GW   = P + 3;
    localparam int CW   = $clog2(IMG_WIDTH);
    localparam int RW   = $clog2(IMG_HEIGHT);
    localparam int CXW  = CW + sem_pkg::COORD_W;
    localparam int RXW  = RW + sem_pkg::COORD_W;
    localparam int PXW  = P + sem_pkg::PIX_IN_W;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_CALC = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    localparam logic [CW-1:0] COL_LAST = CW'(IMG_WIDTH - 1);
    localparam logic [RW-1:0] ROW_LAST = RW'(IMG_HEIGHT - 1);

    function automatic logic [sem_pkg::COORD_W-1:0] col_tag(input logic [CW-1:0] v);
        logic [CXW-1:0] ext;
        ext = CXW'(v);
        return ext[sem_pkg::COORD_W-1:0];
    endfunction

    function automatic logic [sem_pkg::COORD_W-1:0] row_tag(input logic [RW-1:0] v);
        logic [RXW-1:0] ext;
        ext = RXW'(v);
        return ext[sem_pkg::COORD_W-1:0];
    endfunction

    // Line store: one word per column, {row r-2, row r-1}
    logic [2*P-1:0] line_mem [IMG_WIDTH];
    logic [2*P-1:0] rd_reg;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [P-1:0]  px_reg;
    logic [P-1:0]  win_reg [9];
    logic [P-1:0]  win_next [9];
    logic [PXW-1:0] px_ext;

    sem_pkg::sem_job_t job_reg, job_next;
    logic signed [GW-1:0] gx_reg, gy_reg, gx_next, gy_next;
    logic [P-1:0] pa_reg, pb_reg, pc_reg;

    logic signed [GW-1:0] sx [9];
    logic row_first, row_edge, row_bottom, col_one, col_edge, col_end;

    assign px_ext = PXW'(s_pixel);
    assign s_ready = (state_reg == F_IDLE);

    always_comb begin
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = rd_reg[2*P-1:P];
        win_next[3] = win_reg[4];
        win_next[4] = win_reg[5];
        win_next[5] = rd_reg[P-1:0];
        win_next[6] = win_reg[7];
        win_next[7] = win_reg[8];
        win_next[8] = px_reg;
        for (int i = 0; i < 9; i++) begin
            sx[i] = $signed(GW'(win_next[i]));
        end
        gx_next = (sx[2] - sx[0]) + ((sx[5] - sx[3]) <<< 1) + (sx[8] - sx[6]);
        gy_next = (sx[6] - sx[0]) + ((sx[7] - sx[1]) <<< 1) + (sx[8] - sx[2]);
    end

    // Classification of the current pixel position
    always_comb begin
        row_first  = (row_reg == '0);
        row_edge   = (row_reg >= RW'(2));
        row_bottom = (row_reg == ROW_LAST);
        col_one    = (col_reg == CW'(1));
        col_edge   = (col_reg >= CW'(2));
        col_end    = (col_reg == COL_LAST);

        job_next            = '0;
        job_next.has_a      = row_edge && (col_one || col_edge);
        job_next.a_interior = row_edge && col_edge;
        job_next.has_b      = row_edge && col_end;
        job_next.has_c      = row_first || (row_edge && row_bottom);
        job_next.frame_last = row_bottom && col_end;
        job_next.a_row      = row_tag(row_reg - RW'(1));
        job_next.a_col      = col_one ? '0 : col_tag(col_reg - CW'(1));
        job_next.cur_row    = row_tag(row_reg);
        job_next.cur_col    = col_tag(col_reg);
    end

    always_comb begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (s_valid) state_next = F_CALC;
            end
            F_CALC: begin
                state_next = F_PUSH;
                if (col_end) begin
                    col_next = '0;
                    row_next = row_bottom ? '0 : row_reg + RW'(1);
                end else begin
                    col_next = col_reg + CW'(1);
                end
            end
            F_PUSH: begin
                if (!push_valid || push_ready) state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
        end else begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

    // Line store: read on accept, written back at the same column in the following cycle
    always_ff @(posedge aclk) begin
        if (state_reg == F_IDLE && s_valid) begin
            rd_reg <= line_mem[col_reg];
            px_reg <= px_ext[P-1:0];
        end
        if (state_reg == F_CALC) begin
            line_mem[col_reg] <= {rd_reg[P-1:0], px_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == F_CALC) begin
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= win_next[i];
            end
            job_reg <= job_next;
            gx_reg  <= gx_next;
            gy_reg  <= gy_next;
            pa_reg  <= win_next[4];
            pb_reg  <= win_next[5];
            pc_reg  <= px_reg;
        end
    end

    assign push_valid = (state_reg == F_PUSH) &&
                        (job_reg.has_a || job_reg.has_b || job_reg.has_c);
    assign push_job   = job_reg;
    assign push_gx    = gx_reg;
    assign push_gy    = gy_reg;
    assign push_pa    = pa_reg;
    assign push_pb    = pb_reg;
    assign push_pc    = pc_reg;

endmodule

`default_nettype wire

>>> hw/rtl/sem_queue.sv
// Short job queue between front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module sem_queue #(
    parameter int DEPTH  = 2,
    parameter int DATA_W = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire sem_pkg::sem_job_t push_job,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output sem_pkg::sem_job_t      pop_job,
    output logic [DATA_W-1:0]      pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    sem_pkg::sem_job_t  job_mem  [DEPTH];
    logic [DATA_W-1:0]  data_mem [DEPTH];

    logic [PW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [NW-1:0] cnt_reg, cnt_next;
    logic do_push, do_pop;

    assign push_ready = (cnt_reg != NW'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_job    = job_mem[rd_reg];
    assign pop_data   = data_mem[rd_reg];

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push) wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
        if (do_pop)  rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
        if (do_push && !do_pop) cnt_next = cnt_reg + NW'(1);
        if (!do_push && do_pop) cnt_next = cnt_reg - NW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            job_mem[wr_reg]  <= push_job;
            data_mem[wr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/sem_back.sv
// Back end: square root of the gradient energy and result sequencing.
`timescale 1ns / 1ps
`default_nettype none

module sem_back #(
    parameter int PIXEL_BITS = 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          pop_valid,
    output logic                               pop_ready,
    input  wire sem_pkg::sem_job_t             pop_job,
    input  wire logic signed [PIXEL_BITS+2:0]  pop_gx,
    input  wire logic signed [PIXEL_BITS+2:0]  pop_gy,
    input  wire logic [PIXEL_BITS-1:0]         pop_pa,
    input  wire logic [PIXEL_BITS-1:0]         pop_pb,
    input  wire logic [PIXEL_BITS-1:0]         pop_pc,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [sem_pkg::MAG_W-1:0]          m_magnitude,
    output logic [sem_pkg::COORD_W-1:0]        m_out_row,
    output logic [sem_pkg::COORD_W-1:0]        m_out_col,
    output logic                               m_is_border,
    output logic                               m_last_of_run,
    output logic                               m_frame_done
);

    localparam int P     = PIXEL_BITS;
    localparam int GW    = P + 3;
    localparam int AW    = P + 2;            // |G| width
    localparam int RB    = P + 3;            // root bits
    localparam int RADW  = 2 * RB;
    localparam int IW    = $clog2(RB);
    localparam int SAT_W = RB + sem_pkg::MAG_W;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_SQ   = 3'd1;
    localparam logic [2:0] B_SUM  = 3'd2;
    localparam logic [2:0] B_ROOT = 3'd3;
    localparam logic [2:0] B_EMIT = 3'd4;

    function automatic logic [sem_pkg::MAG_W-1:0] sat_mag(input logic [RB-1:0] v);
        logic [SAT_W-1:0] ext;
        ext = SAT_W'(v);
        return (ext > SAT_W'(sem_pkg::MAG_MAX)) ? sem_pkg::MAG_MAX
                                                : ext[sem_pkg::MAG_W-1:0];
    endfunction

    logic [2:0] state_reg, state_next;

    sem_pkg::sem_job_t    job_reg;
    logic signed [GW-1:0] gx_reg, gy_reg;
    logic [P-1:0]         pa_reg, pb_reg, pc_reg;
    logic                 pend_a_reg, pend_b_reg, pend_c_reg;
    logic                 pend_a_next, pend_b_next, pend_c_next;

    logic [2*AW-1:0] sqx_reg, sqy_reg;
    logic [RADW-1:0] rad_reg;
    logic [RB-1:0]   rem_reg, root_reg;
    logic [IW-1:0]   iter_reg;

    logic signed [GW-1:0] gx_abs_s, gy_abs_s;
    logic [AW-1:0]   ax, ay;
    logic [RB+1:0]   rem_sh, trial, diff;
    logic            take;

    // Output register
    logic                        m_valid_reg, m_valid_next;
    logic [sem_pkg::MAG_W-1:0]   mag_reg, mag_next;
    logic [sem_pkg::COORD_W-1:0] row_reg, row_next, col_reg, col_next;
    logic border_reg, border_next, last_reg, last_next, done_reg, done_next;
    logic can_load, load;

    assign gx_abs_s = gx_reg[GW-1] ? -gx_reg : gx_reg;
    assign gy_abs_s = gy_reg[GW-1] ? -gy_reg : gy_reg;
    assign ax       = gx_abs_s[AW-1:0];
    assign ay       = gy_abs_s[AW-1:0];

    // One root bit per cycle, radicand consumed two bits at a time
    assign rem_sh = {rem_reg, rad_reg[RADW-1:RADW-2]};
    assign trial  = {root_reg, 2'b01};
    assign take   = (rem_sh >= trial);
    assign diff   = rem_sh - trial;

    assign pop_ready = (state_reg == B_IDLE);
    assign can_load  = !m_valid_reg || m_ready;
    assign load      = (state_reg == B_EMIT) && can_load;

    always_comb begin
        state_next   = state_reg;
        pend_a_next  = pend_a_reg;
        pend_b_next  = pend_b_reg;
        pend_c_next  = pend_c_reg;
        mag_next     = mag_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        border_next  = border_reg;
        last_next    = last_reg;
        done_next    = done_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            B_IDLE: begin
                if (pop_valid) begin
                    pend_a_next = pop_job.has_a;
                    pend_b_next = pop_job.has_b;
                    pend_c_next = pop_job.has_c;
                    state_next  = (pop_job.has_a && pop_job.a_interior) ? B_SQ : B_EMIT;
                end
            end
            B_SQ:   state_next = B_SUM;
            B_SUM:  state_next = B_ROOT;
            B_ROOT: begin
                if (iter_reg == '0) state_next = B_EMIT;
            end
            B_EMIT: begin
                if (can_load) begin
                    m_valid_next = 1'b1;
                    if (pend_a_reg) begin
                        mag_next    = job_reg.a_interior ? sat_mag(root_reg)
                                                         : sat_mag(RB'(pa_reg));
                        row_next    = job_reg.a_row;
                        col_next    = job_reg.a_col;
                        border_next = !job_reg.a_interior;
                        pend_a_next = 1'b0;
                    end else if (pend_b_reg) begin
                        mag_next    = sat_mag(RB'(pb_reg));
                        row_next    = job_reg.a_row;
                        col_next    = job_reg.cur_col;
                        border_next = 1'b1;
                        pend_b_next = 1'b0;
                    end else begin
                        mag_next    = sat_mag(RB'(pc_reg));
                        row_next    = job_reg.cur_row;
                        col_next    = job_reg.cur_col;
                        border_next = 1'b1;
                        pend_c_next = 1'b0;
                    end
                    last_next = !(pend_a_next || pend_b_next || pend_c_next);
                    done_next = last_next && job_reg.frame_last;
                    if (last_next) state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
            pend_a_reg  <= 1'b0;
            pend_b_reg  <= 1'b0;
            pend_c_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            pend_a_reg  <= pend_a_next;
            pend_b_reg  <= pend_b_next;
            pend_c_reg  <= pend_c_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == B_IDLE && pop_valid) begin
            job_reg <= pop_job;
            gx_reg  <= pop_gx;
            gy_reg  <= pop_gy;
            pa_reg  <= pop_pa;
            pb_reg  <= pop_pb;
            pc_reg  <= pop_pc;
        end
        if (state_reg == B_SQ) begin
            sqx_reg <= ax * ax;
            sqy_reg <= ay * ay;
        end
        if (state_reg == B_SUM) begin
            rad_reg  <= RADW'(sqx_reg) + RADW'(sqy_reg);
            rem_reg  <= '0;
            root_reg <= '0;
            iter_reg <= IW'(RB - 1);
        end
        if (state_reg == B_ROOT) begin
            rad_reg  <= {rad_reg[RADW-3:0], 2'b00};
            rem_reg  <= take ? diff[RB-1:0] : rem_sh[RB-1:0];
            root_reg <= {root_reg[RB-2:0], take};
            iter_reg <= iter_reg - IW'(1);
        end
        if (load) begin
            mag_reg    <= mag_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            border_reg <= border_next;
            last_reg   <= last_next;
            done_reg   <= done_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_magnitude   = mag_reg;
    assign m_out_row     = row_reg;
    assign m_out_col     = col_reg;
    assign m_is_border   = border_reg;
    assign m_last_of_run = last_reg;
    assign m_frame_done  = done_reg;

endmodule

`default_nettype wire

>>> hw/rtl/sobel_edge_magnitude.sv
// Top level of the streaming 3x3 Sobel edge magnitude block.
//
// Pixels arrive in raster order over an IMG_WIDTH x IMG_HEIGHT frame on the
// s_ request channel and results leave on the m_ channel, each tagged with
// its row and column (low six bits) and flagged as border pass-through or
// interior magnitude floor(sqrt(Gx^2 + Gy^2)), saturated at 2047. Results
// trail the input by one row: row 0 passes straight through, row 1 gives
// nothing, and from row 2 each pixel releases the result for the pixel above
// and to its left, with the left and right border pixels of that row beside
// it; on the last row the pixel itself follows, so one request may release
// up to three results, the last one flagged last_of_run and the very last of
// the frame flagged frame_done. The front end handles one pixel at a time
// in three steps (accept with line-store read, window update, job push),
// and the push waits while the job queue is full. For an interior pixel the
// back end takes the job, forms the squares and then their sum, runs the
// square-root unit that resolves one root bit per cycle, and loads the
// result register; each extra border result loads it once more. A pure
// border job is taken and then loads the result register once per result.
// A two-entry job queue lets the front run ahead while the result register
// is stalled. The line stores are not cleared after reset: the first two
// rows of a frame fill them before any window that reads them produces a result.
`timescale 1ns / 1ps
`default_nettype none

module sobel_edge_magnitude #(
    parameter int IMG_WIDTH  = 64,
    parameter int IMG_HEIGHT = 64,
    parameter int PIXEL_BITS = 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [sem_pkg::PIX_IN_W-1:0]  s_pixel,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [sem_pkg::MAG_W-1:0]          m_magnitude,
    output logic [sem_pkg::COORD_W-1:0]        m_out_row,
    output logic [sem_pkg::COORD_W-1:0]        m_out_col,
    output logic                               m_is_border,
    output logic                               m_last_of_run,
    output logic                               m_frame_done
);

    localparam int P      = PIXEL_BITS;
    localparam int GW     = P + 3;
    localparam int DATA_W = 2 * GW + 3 * P;

    // Job data packed as {gx, gy, pa, pb, pc}
    localparam int PC_LO = 0;
    localparam int PB_LO = P;
    localparam int PA_LO = 2 * P;
    localparam int GY_LO = 3 * P;
    localparam int GX_LO = 3 * P + GW;

    logic                 f_valid, f_ready, b_valid, b_ready;
    sem_pkg::sem_job_t    f_job, b_job;
    logic signed [GW-1:0] f_gx, f_gy;
    logic [P-1:0]         f_pa, f_pb, f_pc;
    logic [DATA_W-1:0]    f_data, b_data;

    sem_front #(
        .IMG_WIDTH  (IMG_WIDTH),
        .IMG_HEIGHT (IMG_HEIGHT),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_pixel    (s_pixel),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_job   (f_job),
        .push_gx    (f_gx),
        .push_gy    (f_gy),
        .push_pa    (f_pa),
        .push_pb    (f_pb),
        .push_pc    (f_pc)
    );

    assign f_data = {f_gx, f_gy, f_pa, f_pb, f_pc};

    sem_queue #(
        .DEPTH  (2),
        .DATA_W (DATA_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_job   (f_job),
        .push_data  (f_data),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_job    (b_job),
        .pop_data   (b_data)
    );

    sem_back #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pop_valid     (b_valid),
        .pop_ready     (b_ready),
        .pop_job       (b_job),
        .pop_gx        ($signed(b_data[GX_LO +: GW])),
        .pop_gy        ($signed(b_data[GY_LO +: GW])),
        .pop_pa        (b_data[PA_LO +: P]),
        .pop_pb        (b_data[PB_LO +: P]),
        .pop_pc        (b_data[PC_LO +: P]),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_magnitude   (m_magnitude),
        .m_out_row     (m_out_row),
        .m_out_col     (m_out_col),
        .m_is_border   (m_is_border),
        .m_last_of_run (m_last_of_run),
        .m_frame_done  (m_frame_done)
    );

endmodule

`default_nettype wire

>>> hw/rtl/sem_checker.sv
// Port-level checks for the Sobel edge magnitude block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sem_checker #(
    parameter int IMG_WIDTH  = 64,
    parameter int IMG_HEIGHT = 64,
    parameter int PIXEL_BITS = 8
) (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic [sem_pkg::PIX_IN_W-1:0]  s_pixel,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [sem_pkg::MAG_W-1:0]     m_magnitude,
    input wire logic [sem_pkg::COORD_W-1:0]   m_out_row,
    input wire logic [sem_pkg::COORD_W-1:0]   m_out_col,
    input wire logic                          m_is_border,
    input wire logic                          m_last_of_run,
    input wire logic                          m_frame_done
);

    localparam logic [sem_pkg::COORD_W-1:0] LAST_ROW = sem_pkg::COORD_W'(IMG_HEIGHT - 1);
    localparam logic [sem_pkg::COORD_W-1:0] LAST_COL = sem_pkg::COORD_W'(IMG_WIDTH - 1);
    localparam bit SMALL_FRAME = (IMG_WIDTH <= 64) && (IMG_HEIGHT <= 64);
    localparam bit NARROW_PIX  = (PIXEL_BITS < sem_pkg::MAG_W);

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_magnitude) &&
        $stable(m_out_row) && $stable(m_out_col) && $stable(m_is_border))
        else $error("result changed while stalled");

    // Reset empties the result register
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Frame end is the last result of its pixel, at the bottom-right corner
    a_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_done |-> m_last_of_run && m_is_border &&
        m_out_row == LAST_ROW && m_out_col == LAST_COL)
        else $error("frame end at wrong place");

    // Interior results never sit on the frame edge
    a_interior: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_border && SMALL_FRAME |->
        m_out_row != '0 && m_out_col != '0 &&
        m_out_row != LAST_ROW && m_out_col != LAST_COL)
        else $error("interior result on edge");

    // Border pass-through stays within pixel range
    a_border: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_border && NARROW_PIX |-> (m_magnitude >> PIXEL_BITS) == '0)
        else $error("border value out of pixel range");

endmodule

bind sobel_edge_magnitude sem_checker #(
    .IMG_WIDTH  (IMG_WIDTH),
    .IMG_HEIGHT (IMG_HEIGHT),
    .PIXEL_BITS (PIXEL_BITS)
) u_sem_checker (.*);

`default_nettype wire

>>> bench/tb_top.sv
// Self-checking bench for the streaming 3x3 Sobel edge magnitude block.
`timescale 1ns / 1ps

module tb_top;

    // Frame geometry of the block as instantiated
    localparam int FRAME_W     = 64;
    localparam int FRAME_H     = 64;
    localparam int PIX_BITS    = 8;

    // Drain outlasts an interior job plus its extra border results
    localparam int DRAIN_CYCLES = 64;
    localparam int FLUSH_LIMIT  = 50000;
    localparam longint TIMEOUT_NS = 64'd2_000_000;

    // One result as it leaves the m_ channel
    typedef struct packed {
        logic [sem_pkg::MAG_W-1:0]   mag;
        logic [sem_pkg::COORD_W-1:0] row;
        logic [sem_pkg::COORD_W-1:0] col;
        logic                        border;
        logic                        last;
        logic                        done;
    } sobel_out_t;

    // Picture content used for a run of sixteen pixels
    typedef enum int {
        TEX_NOISE,
        TEX_FLAT,
        TEX_BINARY,
        TEX_RAMP,
        TEX_STRIPES
    } texture_t;

    logic                          aclk    = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid;
    logic                          s_ready;
    logic [sem_pkg::PIX_IN_W-1:0]  s_pixel;
    logic                          m_valid;
    logic                          m_ready;
    logic [sem_pkg::MAG_W-1:0]     m_magnitude;
    logic [sem_pkg::COORD_W-1:0]   m_out_row;
    logic [sem_pkg::COORD_W-1:0]   m_out_col;
    logic                          m_is_border;
    logic                          m_last_of_run;
    logic                          m_frame_done;

    // Predictor state: two previous rows, the 3x3 window, next pixel position
    logic [PIX_BITS-1:0]  line_m2 [FRAME_W];
    logic [PIX_BITS-1:0]  line_m1 [FRAME_W];
    logic [PIX_BITS-1:0]  win     [9];
    int                   next_row;
    int                   next_col;

    sobel_out_t           pending_results [$];
    int                   fail_count;

    // Idle rates in percent, and the receiver's long hold-off in cycles
    int                   send_idle_pct;
    int                   recv_idle_pct;
    int                   hold_left = 0;

    // Content generator state
    texture_t             texture;
    logic [7:0]           tex_base;
    int                   tex_step;

    sobel_edge_magnitude #(
        .IMG_WIDTH  (FRAME_W),
        .IMG_HEIGHT (FRAME_H),
        .PIXEL_BITS (PIX_BITS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel       (s_pixel),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_magnitude   (m_magnitude),
        .m_out_row     (m_out_row),
        .m_out_col     (m_out_col),
        .m_is_border   (m_is_border),
        .m_last_of_run (m_last_of_run),
        .m_frame_done  (m_frame_done)
    );

    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic sobel_out_t make_result(input int mag, input int row,
                                               input int col, input bit border);
        sobel_out_t res;
        res.mag    = mag[sem_pkg::MAG_W-1:0];
        res.row    = row[sem_pkg::COORD_W-1:0];
        res.col    = col[sem_pkg::COORD_W-1:0];
        res.border = border;
        res.last   = 1'b0;
        res.done   = 1'b0;
        return res;
    endfunction

    // floor(sqrt(Gx^2 + Gy^2)) over the current window, saturated to the field
    function automatic int gradient_floor_root();
        int gx;
        int gy;
        longint sq;
        longint root;
        longint cand;
        gx = int'(win[2]) - int'(win[0]) + 2 * (int'(win[5]) - int'(win[3]))
           + int'(win[8]) - int'(win[6]);
        gy = int'(win[6]) - int'(win[0]) + 2 * (int'(win[7]) - int'(win[1]))
           + int'(win[8]) - int'(win[2]);
        sq   = longint'(gx) * gx + longint'(gy) * gy;
        root = 0;
        // One root bit per pass, top down
        for (int b = 15; b >= 0; b--) begin
            cand = root + (longint'(1) << b);
            if (cand * cand <= sq)
                root = cand;
        end
        if (root > longint'(sem_pkg::MAG_MAX))
            root = longint'(sem_pkg::MAG_MAX);
        return int'(root);
    endfunction

    // Advance the predictor by one accepted request and queue what it releases
    function automatic void predict_pixel(input logic [sem_pkg::PIX_IN_W-1:0] px_in);
        sobel_out_t batch [$];
        logic [PIX_BITS-1:0] px;
        int r;
        int c;
        px = px_in[PIX_BITS-1:0];
        r  = next_row;
        c  = next_col;

        for (int i = 0; i < 3; i++) begin
            win[i*3 + 0] = win[i*3 + 1];
            win[i*3 + 1] = win[i*3 + 2];
        end
        win[2]     = line_m2[c];
        win[5]     = line_m1[c];
        win[8]     = px;
        line_m2[c] = line_m1[c];
        line_m1[c] = px;

        if (r == 0) begin
            batch.push_back(make_result(int'(px), 0, c, 1'b1));
        end else if (r >= 2) begin
            if (c == 1) begin
                batch.push_back(make_result(int'(win[4]), r - 1, 0, 1'b1));
            end else if (c >= 2) begin
                batch.push_back(make_result(gradient_floor_root(), r - 1, c - 1, 1'b0));
                if (c == FRAME_W - 1)
                    batch.push_back(make_result(int'(win[5]), r - 1, c, 1'b1));
            end
            if (r == FRAME_H - 1)
                batch.push_back(make_result(int'(px), r, c, 1'b1));
        end

        if (batch.size() > 0) begin
            batch[batch.size() - 1].last = 1'b1;
            if (r == FRAME_H - 1 && c == FRAME_W - 1)
                batch[batch.size() - 1].done = 1'b1;
        end
        foreach (batch[k])
            pending_results.push_back(batch[k]);

        c++;
        if (c >= FRAME_W) begin
            c = 0;
            r++;
            if (r >= FRAME_H)
                r = 0;
        end
        next_row = r;
        next_col = c;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Picks the next pixel; content changes every sixteen columns so that
    // flat areas, hard edges, gradients and noise all reach the window
    function automatic logic [7:0] next_pixel();
        logic [7:0] px;
        if (next_col % 16 == 0) begin
            case ($urandom_range(0, 7))
                3:       texture = TEX_FLAT;
                4:       texture = TEX_BINARY;
                5:       texture = TEX_RAMP;
                6:       texture = TEX_STRIPES;
                default: texture = TEX_NOISE;
            endcase
            tex_base = 8'($urandom_range(0, 255));
            tex_step = $urandom_range(1, 9);
        end
        case (texture)
            TEX_FLAT:    px = tex_base;
            TEX_BINARY:  px = $urandom_range(0, 1) ? 8'hff : 8'h00;
            TEX_RAMP:    px = 8'(int'(tex_base) + next_col * tex_step);
            TEX_STRIPES: px = (((next_col / tex_step) + next_row) % 2) ? 8'hff : 8'h00;
            default:     px = 8'($urandom_range(0, 255));
        endcase
        return px;
    endfunction

    // Offers one pixel after a random gap and returns once it is taken.
    // Handshake is sampled mid-cycle, the request lands on the next edge.
    task automatic send_pixel(input logic [sem_pkg::PIX_IN_W-1:0] px);
        bit taken;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= px;
        taken = 1'b0;
        while (!taken) begin
            @(negedge aclk);
            taken = s_ready;
            if (taken)
                predict_pixel(px);
            @(posedge aclk);
        end
    endtask

    // Start of row 0: every bit of the pixel low and high, passed straight
    // through as border results
    task automatic test_row0_extremes();
        logic [7:0] pattern [24];
        pattern = '{8'h00, 8'hff, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20,
                    8'h40, 8'h80, 8'hfe, 8'hfd, 8'hfb, 8'hf7, 8'hef, 8'hdf,
                    8'hbf, 8'h7f, 8'haa, 8'h55, 8'h0f, 8'hf0, 8'h00, 8'hff};
        foreach (pattern[i])
            send_pixel(pattern[i]);
    endtask

    // Plain raster stream with mixed content
    task automatic test_random_raster(input int count);
        repeat (count)
            send_pixel(next_pixel());
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering,
    // so the job queue fills and s_ready drops
    task automatic test_backpressure();
        int saved_idle;
        saved_idle    = send_idle_pct;
        send_idle_pct = 0;
        hold_left     = 600;
        repeat (48)
            send_pixel(next_pixel());
        send_idle_pct = saved_idle;
    endtask

    // ------------------------------------------------------------------
    // Receiver and result checking
    // ------------------------------------------------------------------

    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Results are sampled mid-cycle; a result counts when valid and ready
    // are both high ahead of the next rising edge
    initial begin
        sobel_out_t want;
        forever begin
            @(negedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result row %0d col %0d magnitude %0d",
                           m_out_row, m_out_col, m_magnitude);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    compare_field("magnitude",   want.mag,    m_magnitude);
                    compare_field("out_row",     want.row,    m_out_row);
                    compare_field("out_col",     want.col,    m_out_col);
                    compare_field("is_border",   want.border, m_is_border);
                    compare_field("last_of_run", want.last,   m_last_of_run);
                    compare_field("frame_done",  want.done,   m_frame_done);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        int waited;
        s_valid    = 1'b0;
        s_pixel    = '0;
        fail_count = 0;
        next_row   = 0;
        next_col   = 0;
        texture    = TEX_NOISE;
        tex_base   = 8'h00;
        tex_step   = 1;
        foreach (line_m2[i]) begin
            line_m2[i] = '0;
            line_m1[i] = '0;
        end
        foreach (win[i])
            win[i] = '0;
        send_idle_pct = 36;
        recv_idle_pct = 72;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Sender sparse, receiver slow
        test_row0_extremes();
        test_random_raster(136);

        // The other way round, with the long hold-off in the middle
        send_idle_pct = 72;
        recv_idle_pct = 36;
        test_random_raster(70);
        test_backpressure();
        test_random_raster(70);

        // Full rate on both sides, requests back to back
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_raster(102);

        s_valid <= 1'b0;
        waited = 0;
        while (pending_results.size() > 0 && waited < FLUSH_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (pending_results.size() > 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            fail_count++;
        end
        // Let any stray result show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
